FILE: rtl/core/tcce_pkg.sv
// Package for the text console character engine.
// Holds the store geometry, field widths, character codes and the
// command and status words between controller and datapath. No dependencies.
package tcce_pkg;

  // Screen geometry
  localparam int ROWS    = 25;
  localparam int COLUMNS = 80;
  localparam int CELLS   = ROWS * COLUMNS;

  // Internal widths that follow from the geometry
  localparam int CELL_AW = $clog2(CELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS + 1);

  // Word field widths
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int DATA_W  = 16;
  localparam int CROW_W  = 5;
  localparam int CCOL_W  = 7;
  localparam int ATTR_W  = 8;

  // Configuration port
  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;
  localparam logic [REG_IDX_W-1:0] REG_ATTR = 1'b0;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Kind of store sweep in progress
  typedef enum logic [2:0] {
    SW_NONE  = 3'd0,
    SW_INIT  = 3'd1,
    SW_CLEAR = 3'd2,
    SW_COPY  = 3'd3,
    SW_BLANK = 3'd4
  } sweep_e;

  // Controller to datapath
  typedef struct packed {
    logic   load;
    logic   rd;
    logic   wr_char;
    logic   wr_space;
    logic   bs_erase;
    logic   bs_up;
    logic   cr;
    logic   lf;
    logic   home;
    logic   sweep_init;
    sweep_e sweep;
    logic   out_load;
  } tcce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic is_lf;
    logic is_cr;
    logic is_bs;
    logic is_tab;
    logic col_zero;
    logic row_zero;
    logic row_bottom;
    logic wrap;
    logic tab_more;
    logic copy_last;
    logic sweep_last;
  } tcce_stat_t;

endpackage

FILE: rtl/core/tcce_in_if.sv
// Input channel of the console engine: valid/ready plus one item word.
// Depends on tcce_pkg for the field widths.
interface tcce_in_if import tcce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, mode, char_code, cell_index, input ready);
  modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

FILE: rtl/core/tcce_out_if.sv
// Result channel of the console engine: valid/ready plus one result word.
// Depends on tcce_pkg for the field widths.
interface tcce_out_if import tcce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] cell_data;
  logic [CROW_W-1:0] cursor_row;
  logic [CCOL_W-1:0] cursor_col;

  modport source (output valid, cell_data, cursor_row, cursor_col, input ready);
  modport sink   (input valid, cell_data, cursor_row, cursor_col, output ready);
endinterface

FILE: rtl/core/text_console_character_engine.sv
// Text console character engine: 80x25 cell store with cursor and row ends.
// Each word is taken in the idle state, worked on in the execute state and in any
// tab, scroll, blank, post or clear state it needs, then held in the done state
// until the result channel is free; a bottom-row line feed scrolls the store.
// One word at a time: no new word is taken until the last result is loaded.
// Reset: asynchronous, active low; then a space fill of the store, no word taken.
module text_console_character_engine import tcce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcce_in_if.sink            item_i,
  tcce_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  tcce_cmd_t         cmd;
  tcce_stat_t        stat;
  logic [ATTR_W-1:0] attr_q;
  logic              reg_hit;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_ATTR);
  assign prdata  = reg_hit ? PDATA_W'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (psel && penable && pwrite && reg_hit) begin
      attr_q <= pwdata[ATTR_W-1:0];
    end
  end

  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcce_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .attr_i       (attr_q),
    .mode_i       (item_i.mode),
    .char_code_i  (item_i.char_code),
    .cell_index_i (item_i.cell_index),
    .cell_data_o  (result_o.cell_data),
    .cursor_row_o (result_o.cursor_row),
    .cursor_col_o (result_o.cursor_col)
  );

endmodule

FILE: rtl/core/tcce_datapath.sv
// Datapath of the console engine: cell store, cursor, row end table,
// sweep counter and result register. Driven by tcce_ctrl; uses tcce_pkg.
module tcce_datapath import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcce_cmd_t         cmd_i,
  output tcce_stat_t        stat_o,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [IDX_W-1:0]  cell_index_i,
  output logic [DATA_W-1:0] cell_data_o,
  output logic [CROW_W-1:0] cursor_row_o,
  output logic [CCOL_W-1:0] cursor_col_o
);

  // Item word held while it is worked on
  logic [MODE_W-1:0] mode_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;

  // Cursor, row end table and sweep counter
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [COL_W-1:0]   row_end_q [ROWS];
  logic [CELL_AW-1:0] cnt_q, cnt_d;

  // Cell store
  logic [DATA_W-1:0]  cells_q [CELLS];
  logic [DATA_W-1:0]  rdata_q;

  // Result word
  logic [DATA_W-1:0]  cell_data_q;
  logic [CROW_W-1:0]  row_out_q;
  logic [CCOL_W-1:0]  col_out_q;

  logic               we, re;
  logic [CELL_AW-1:0] waddr, raddr, cur_addr;
  logic [DATA_W-1:0]  wdata, space_cell;
  logic [COL_W-1:0]   col_inc, prev_end;
  logic [ROW_W-1:0]   prev_row;
  logic               row_bottom, idx_ok;

  assign cur_addr   = CELL_AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign space_cell = {attr_i, SPACE_CHAR};
  assign col_inc    = col_q + COL_W'(1);
  assign prev_row   = row_q - ROW_W'(1);
  assign row_bottom = (32'(row_q) == ROWS - 1);
  assign idx_ok     = (32'(idx_q) < CELLS);

  // Recorded end of the row above, held to the wrap column
  always_comb begin
    prev_end = row_end_q[prev_row];
    if (32'(prev_end) > COLUMNS) begin
      prev_end = COL_W'(COLUMNS);
    end
  end

  // Status for the controller
  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.is_lf      = (char_q == CH_LF);
    stat_o.is_cr      = (char_q == CH_CR);
    stat_o.is_bs      = (char_q == CH_BS);
    stat_o.is_tab     = (char_q == CH_TAB);
    stat_o.col_zero   = (col_q == '0);
    stat_o.row_zero   = (row_q == '0);
    stat_o.row_bottom = row_bottom;
    stat_o.wrap       = (32'(col_q) >= COLUMNS);
    // tab stops at the next multiple of four or at the wrap column
    stat_o.tab_more   = (col_inc[1:0] != 2'b00) && (32'(col_inc) < COLUMNS);
    stat_o.copy_last  = (cnt_q == CELL_AW'(CELLS - COLUMNS));
    stat_o.sweep_last = (cnt_q == CELL_AW'(CELLS - 1));
  end

  // Store port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cur_addr;
    wdata = space_cell;
    raddr = CELL_AW'(idx_q);
    if (cmd_i.wr_char) begin
      we    = 1'b1;
      wdata = {attr_i, char_q};
    end
    if (cmd_i.wr_space) begin
      we = 1'b1;
    end
    if (cmd_i.bs_erase) begin
      we    = 1'b1;
      waddr = cur_addr - CELL_AW'(1);
    end
    if (cmd_i.rd) begin
      re = 1'b1;
    end
    case (cmd_i.sweep)
      SW_INIT: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {RESET_ATTR, SPACE_CHAR};
      end
      SW_CLEAR, SW_BLANK: begin
        we    = 1'b1;
        waddr = cnt_q;
      end
      SW_COPY: begin
        // read one row ahead, write the word read in the cycle before
        re    = !stat_o.copy_last;
        raddr = cnt_q + CELL_AW'(COLUMNS);
        we    = (cnt_q != '0);
        waddr = cnt_q - CELL_AW'(1);
        wdata = rdata_q;
      end
      default: ;
    endcase
  end

  // Cell store
  always_ff @(posedge clk_i) begin
    if (we) begin
      cells_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= cells_q[raddr];
    end
  end

  // Cursor and counter next values
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    cnt_d = cnt_q;
    if (cmd_i.wr_char || cmd_i.wr_space) begin
      col_d = col_inc;
    end
    if (cmd_i.bs_erase) begin
      col_d = col_q - COL_W'(1);
    end
    if (cmd_i.bs_up) begin
      row_d = prev_row;
      col_d = prev_end;
    end
    if (cmd_i.cr) begin
      col_d = '0;
    end
    if (cmd_i.lf) begin
      col_d = '0;
      if (!row_bottom) begin
        row_d = row_q + ROW_W'(1);
      end
    end
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end
    // the last copy step leaves the counter on the first bottom-row cell
    if (cmd_i.sweep != SW_NONE && !(cmd_i.sweep == SW_COPY && stat_o.copy_last)) begin
      cnt_d = cnt_q + CELL_AW'(1);
    end
    if (cmd_i.sweep_init) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  // Row end table: line feed records the column, scrolling moves it up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        row_end_q[r] <= '0;
      end
    end else if (cmd_i.lf) begin
      if (row_bottom) begin
        for (int r = 0; r < ROWS - 2; r++) begin
          row_end_q[r] <= row_end_q[r+1];
        end
        row_end_q[ROWS-2] <= col_q;
        row_end_q[ROWS-1] <= col_q;
      end else begin
        row_end_q[row_q] <= col_q;
      end
    end
  end

  // Item and result words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      char_q <= char_code_i;
      idx_q  <= cell_index_i;
    end
    if (cmd_i.out_load) begin
      cell_data_q <= (mode_q == MODE_READ && idx_ok) ? rdata_q : '0;
      row_out_q   <= CROW_W'(row_q);
      col_out_q   <= CCOL_W'(col_q);
    end
  end

  assign cell_data_o  = cell_data_q;
  assign cursor_row_o = row_out_q;
  assign cursor_col_o = col_out_q;

endmodule

FILE: rtl/core/tcce_ctrl.sv
// Controller of the console engine: one-hot state machine that sequences
// each item, the store sweeps and the result handshake. Uses tcce_pkg.
module tcce_ctrl import tcce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  tcce_stat_t stat_i,
  output tcce_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_INIT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_EXEC   = 11'b000_0000_0100,
    S_READ   = 11'b000_0000_1000,
    S_TAB    = 11'b000_0001_0000,
    S_SCROLL = 11'b000_0010_0000,
    S_BLANK  = 11'b000_0100_0000,
    S_POST   = 11'b000_1000_0000,
    S_CLEAR  = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = SW_INIT;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (stat_i.mode)
          MODE_READ: begin
            cmd_o.rd = 1'b1;
          end
          MODE_CLEAR: begin
            cmd_o.home       = 1'b1;
            cmd_o.sweep_init = 1'b1;
            state_d          = S_CLEAR;
          end
          MODE_PUT: begin
            if (stat_i.is_lf || ((stat_i.is_tab || !(stat_i.is_cr || stat_i.is_bs))
                                 && stat_i.wrap)) begin
              // line feed, or the deferred wrap ahead of a tab or character
              cmd_o.lf         = 1'b1;
              cmd_o.sweep_init = stat_i.row_bottom;
              state_d          = stat_i.row_bottom ? S_SCROLL : S_POST;
            end else if (stat_i.is_cr) begin
              cmd_o.cr = 1'b1;
            end else if (stat_i.is_bs) begin
              if (!stat_i.col_zero) begin
                cmd_o.bs_erase = 1'b1;
              end else if (!stat_i.row_zero) begin
                cmd_o.bs_up = 1'b1;
              end
            end else if (stat_i.is_tab) begin
              state_d = S_TAB;
            end else begin
              cmd_o.wr_char = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_TAB: begin
        cmd_o.wr_space = 1'b1;
        if (!stat_i.tab_more) begin
          state_d = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd_o.sweep = SW_COPY;
        if (stat_i.copy_last) begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd_o.sweep = SW_BLANK;
        if (stat_i.sweep_last) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        // work left over after a line feed
        if (stat_i.is_tab) begin
          state_d = S_TAB;
        end else begin
          cmd_o.wr_char = !stat_i.is_lf;
          state_d       = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep = SW_CLEAR;
        if (stat_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/tcce_checker.sv
// Port checker for the console engine, bound to the top level.
// Depends on tcce_pkg and the top level's ports.
module tcce_checker import tcce_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] cell_data_i,
  input logic [CROW_W-1:0] cursor_row_i,
  input logic [CCOL_W-1:0] cursor_col_i
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_data_i)
      && $stable(cursor_row_i) && $stable(cursor_col_i))
    else $error("result word changed while stalled");

  // One word at a time: no take in the cycle after a take
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on back to back cycles");

  // Cursor row stays on the screen, column at most the wrap column
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(cursor_row_i) < ROWS)
    else $error("cursor row beyond the last row");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(cursor_col_i) <= COLUMNS)
    else $error("cursor column beyond the wrap column");

endmodule

bind text_console_character_engine tcce_checker u_tcce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .cell_data_i  (result_o.cell_data),
  .cursor_row_i (result_o.cursor_row),
  .cursor_col_i (result_o.cursor_col)
);
